[rtl/dlga_pkg.sv]
// shared types and constants of the dense layer gradient accumulator
package dlga_pkg;

  // input word kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // register indexes of the configuration port
  localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd1;
  localparam logic [1:0] REG_USE_BIAS     = 2'd2;

  localparam int VALUE_W     = 16;
  localparam int PROD_W      = 32;
  localparam int BIAS_SHIFT  = 12;
  localparam int QUEUE_DEPTH = 2;

  // decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERROR,
    OP_READ_W,
    OP_READ_B,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic                      last;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

[rtl/dlga_front.sv]
// front end: accepts input words, classifies them and queues commands
module dlga_front
  import dlga_pkg::*;
#(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 64,
  parameter int IDX_W       = 6,
  parameter int COL_W       = 7,
  parameter int OCW         = 7,
  parameter int RB          = 6,
  parameter int CB          = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                kind,
  input  logic [IDX_W-1:0]          index,
  input  logic [COL_W-1:0]          column,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      last_in_batch,
  input  logic [OCW-1:0]            output_count,
  output logic                      cmd_valid,
  input  logic                      cmd_ready,
  output cmd_t                      cmd,
  output logic [RB-1:0]             cmd_row,
  output logic [CB-1:0]             cmd_col
);

  localparam int CMP_W = ((IDX_W > COL_W) ? ((IDX_W > OCW) ? IDX_W : OCW)
                                          : ((COL_W > OCW) ? COL_W : OCW)) + 1;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t          cls;
  logic [RB-1:0] cls_row;
  logic [CB-1:0] cls_col;
  logic [CMP_W-1:0] idx_x;
  logic [CMP_W-1:0] col_x;

  cmd_t          q_cmd [QUEUE_DEPTH];
  logic [RB-1:0] q_row [QUEUE_DEPTH];
  logic [CB-1:0] q_col [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push;
  logic pop;

  // classify the incoming word
  always_comb begin
    idx_x     = CMP_W'(index);
    col_x     = CMP_W'(column);
    cls.op    = OP_NONE;
    cls.last  = 1'b0;
    cls.value = value;
    cls_row   = index[RB-1:0];
    cls_col   = column[CB-1:0];
    case (kind)
      KIND_LOAD: begin
        cls_col = index[CB-1:0];
        if (idx_x < CMP_W'(MAX_INPUTS)) cls.op = OP_LOAD;
      end
      KIND_ERROR: begin
        cls.last = last_in_batch;
        if (idx_x < CMP_W'(output_count) && idx_x < CMP_W'(MAX_OUTPUTS)) cls.op = OP_ERROR;
      end
      KIND_READ: begin
        if (idx_x < CMP_W'(MAX_OUTPUTS)) begin
          if (col_x < CMP_W'(MAX_INPUTS)) cls.op = OP_READ_W;
          else if (col_x == CMP_W'(MAX_INPUTS)) cls.op = OP_READ_B;
        end
      end
      KIND_CLEAR: cls.op = OP_CLEAR;
      default: cls.op = OP_NONE;
    endcase
  end

  assign in_ready  = (count != CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_cmd[rd_ptr];
  assign cmd_row   = q_row[rd_ptr];
  assign cmd_col   = q_col[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd[wr_ptr] <= cls;
      q_row[wr_ptr] <= cls_row;
      q_col[wr_ptr] <= cls_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[rtl/dlga_back.sv]
// back end: executes queued commands against the activation and gradient stores
module dlga_back
  import dlga_pkg::*;
#(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 64,
  parameter int ACC_WIDTH   = 40,
  parameter int RB          = 6,
  parameter int CB          = 6,
  parameter int CNT_W       = 7,
  parameter int ADDR_W      = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  cmd_t                        cmd,
  input  logic [RB-1:0]               cmd_row,
  input  logic [CB-1:0]               cmd_col,
  input  logic [CNT_W-1:0]            input_count,
  input  logic                        use_bias,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [ACC_WIDTH-1:0] read_data,
  output logic                        saturated,
  output logic                        batch_done
);

  localparam int W_DEPTH = MAX_INPUTS * MAX_OUTPUTS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_READ,
    S_RWAIT,
    S_DONE
  } state_t;

  state_t state;

  logic [ACC_WIDTH-1:0]      wmem [W_DEPTH];
  logic [ACC_WIDTH-1:0]      bmem [MAX_OUTPUTS];
  logic signed [VALUE_W-1:0] amem [MAX_INPUTS];

  logic [MAX_OUTPUTS-1:0] row_valid;
  logic                   sticky;

  cmd_t           cur;
  logic [RB-1:0]  cur_row;
  logic [CB-1:0]  cur_col;
  logic [CNT_W-1:0] cur_n;
  logic [CNT_W-1:0] cur_lim;
  logic [CNT_W-1:0] i;
  logic           fresh;
  logic           bias_pend;
  logic [ACC_WIDTH-1:0] rd_hold;

  logic [ACC_WIDTH-1:0]      w_rd;
  logic [ACC_WIDTH-1:0]      b_rd;
  logic signed [VALUE_W-1:0] a_rd;

  logic          s1_v;
  logic          s1_bias;
  logic          s1_zero;
  logic [CB-1:0] s1_col;
  logic          s2_v;
  logic          s2_bias;
  logic [CB-1:0] s2_col;
  logic signed [PROD_W-1:0] s2_prod;
  logic [ACC_WIDTH-1:0]     s2_old;

  logic [CNT_W-1:0]          n_eff;
  logic                      walk_w;
  logic                      walk_b;
  logic [CB-1:0]             rd_col;
  logic [ADDR_W-1:0]         w_raddr;
  logic [ADDR_W-1:0]         w_waddr;
  logic signed [VALUE_W-1:0] err_val;
  logic signed [PROD_W-1:0]  mul;
  logic signed [PROD_W-1:0]  bias_add;
  logic [ACC_WIDTH:0]        sum;
  logic                      sat;
  logic [ACC_WIDTH-1:0]      wdata;
  logic                      wr_w;
  logic                      wr_b;
  logic                      act_we;

  assign cmd_ready = (state == S_IDLE);
  assign act_we    = cmd_valid && cmd_ready && (cmd.op == OP_LOAD);
  assign n_eff     = (input_count > CNT_W'(MAX_INPUTS)) ? CNT_W'(MAX_INPUTS) : input_count;

  // walk issue: weight columns first, then the bias slot
  assign walk_w  = (state == S_WALK) && (i < cur_lim);
  assign walk_b  = (state == S_WALK) && !walk_w && bias_pend;
  assign rd_col  = (state == S_WALK) ? i[CB-1:0] : cur_col;
  assign w_raddr = ADDR_W'(cur_row) * ADDR_W'(MAX_INPUTS) + ADDR_W'(rd_col);
  assign w_waddr = ADDR_W'(cur_row) * ADDR_W'(MAX_INPUTS) + ADDR_W'(s2_col);

  assign err_val  = cur.value;
  assign mul      = err_val * a_rd;
  assign bias_add = use_bias
                  ? {{(PROD_W-VALUE_W-BIAS_SHIFT){err_val[VALUE_W-1]}}, err_val,
                     {BIAS_SHIFT{1'b0}}}
                  : '0;

  // saturating accumulate
  always_comb begin
    sum = {s2_old[ACC_WIDTH-1], s2_old}
        + {{(ACC_WIDTH+1-PROD_W){s2_prod[PROD_W-1]}}, s2_prod};
    sat = (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]);
    if (!sat)              wdata = sum[ACC_WIDTH-1:0];
    else if (sum[ACC_WIDTH]) wdata = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    else                   wdata = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  end

  assign wr_w = s2_v && !s2_bias;
  assign wr_b = s2_v && s2_bias;

  always_ff @(posedge clk) begin
    if (wr_w) wmem[w_waddr] <= wdata;
    w_rd <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_b) bmem[cur_row] <= wdata;
    b_rd <= bmem[cur_row];
  end

  always_ff @(posedge clk) begin
    if (act_we) amem[cmd_col] <= cmd.value;
    a_rd <= amem[i[CB-1:0]];
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_bias <= walk_b;
    s1_col  <= i[CB-1:0];
    s1_zero <= (i >= cur_n);
    s2_bias <= s1_bias;
    s2_col  <= s1_col;
    s2_old  <= fresh ? '0 : (s1_bias ? b_rd : w_rd);
    if (s1_bias)      s2_prod <= bias_add;
    else if (s1_zero) s2_prod <= '0;
    else              s2_prod <= mul;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sticky    <= 1'b0;
      row_valid <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
    end else begin
      s1_v <= walk_w || walk_b;
      s2_v <= s1_v;
      if (s2_v && sat) sticky <= 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur     <= cmd;
            cur_row <= cmd_row;
            cur_col <= cmd_col;
            rd_hold <= '0;
            case (cmd.op)
              OP_ERROR: begin
                fresh              <= !row_valid[cmd_row];
                row_valid[cmd_row] <= 1'b1;
                i                  <= '0;
                cur_n              <= n_eff;
                cur_lim            <= row_valid[cmd_row] ? n_eff : CNT_W'(MAX_INPUTS);
                bias_pend          <= !row_valid[cmd_row] || use_bias;
                state              <= S_WALK;
              end
              OP_READ_W, OP_READ_B: state <= S_READ;
              OP_CLEAR: begin
                row_valid <= '0;
                sticky    <= 1'b0;
                state     <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_WALK: begin
          if (walk_w)      i <= i + 1'b1;
          else if (walk_b) bias_pend <= 1'b0;
          else             state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!s1_v && !s2_v) state <= S_DONE;
        end
        S_READ: state <= S_RWAIT;
        S_RWAIT: begin
          if (!row_valid[cur_row])   rd_hold <= '0;
          else if (cur.op == OP_READ_B) rd_hold <= b_rd;
          else                       rd_hold <= w_rd;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            read_data  <= rd_hold;
            batch_done <= cur.last;
            saturated  <= sticky;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/dense_layer_gradient_accumulator_top.sv]
// top level of the dense layer gradient accumulator: config registers, front and back
//
//  channel   | handshake          | contents
//  ----------+--------------------+-------------------------------------------------
//  input     | in_valid/in_ready  | kind, index, column, value, last_in_batch
//  output    | out_valid/out_ready| read_data, saturated, batch_done (one per word)
//  config    | apb psel/penable   | input_count @0x0, output_count @0x4, use_bias @0x8
//
//  an error word walks n weight columns, then the bias slot if use_bias is set, n being
//  the clamped input_count, or all MAX_INPUTS columns and the bias slot on the first
//  update of a row after a reset or clear; the walk does one weight read-modify-write per
//  cycle through a three-stage read, multiply, saturating-add pipeline on a
//  single-port-write gradient memory; reads pass S_READ and S_RWAIT, the rest go to S_DONE
//  reset and clear act through per-row valid flags: an unmarked row reads zero and is
//  fully rewritten on its next update, so no clearing pass runs
//  a two-word queue sits between front and back; a stalled output holds the back
//  end while the front keeps accepting until the queue fills
module dense_layer_gradient_accumulator_top
  import dlga_pkg::*;
#(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 64,
  parameter int ACC_WIDTH   = 40,
  localparam int MAX_IO     = (MAX_INPUTS > MAX_OUTPUTS) ? MAX_INPUTS : MAX_OUTPUTS,
  localparam int IDX_W      = (MAX_IO > 1) ? $clog2(MAX_IO) : 1,
  localparam int COL_W      = $clog2(MAX_INPUTS + 1),
  localparam int CNT_W      = $clog2(MAX_INPUTS + 1),
  localparam int OCW        = $clog2(MAX_OUTPUTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  // input words
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  kind,
  input  logic [IDX_W-1:0]            index,
  input  logic [COL_W-1:0]            column,
  input  logic signed [VALUE_W-1:0]   value,
  input  logic                        last_in_batch,
  // result words
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [ACC_WIDTH-1:0] read_data,
  output logic                        saturated,
  output logic                        batch_done,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int RB     = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int CB     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int ADDR_W = (MAX_INPUTS * MAX_OUTPUTS > 1)
                        ? $clog2(MAX_INPUTS * MAX_OUTPUTS) : 1;

  logic [CNT_W-1:0] input_count;
  logic [OCW-1:0]   output_count;
  logic             use_bias;
  logic             cfg_we;

  logic          cmd_valid;
  logic          cmd_ready;
  cmd_t          cmd;
  logic [RB-1:0] cmd_row;
  logic [CB-1:0] cmd_col;

  // configuration registers, word addressed
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count  <= CNT_W'(MAX_INPUTS);
      output_count <= OCW'(MAX_OUTPUTS);
      use_bias     <= 1'b1;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_INPUT_COUNT:  input_count  <= pwdata[CNT_W-1:0];
        REG_OUTPUT_COUNT: output_count <= pwdata[OCW-1:0];
        REG_USE_BIAS:     use_bias     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INPUT_COUNT:  prdata = 32'(input_count);
      REG_OUTPUT_COUNT: prdata = 32'(output_count);
      REG_USE_BIAS:     prdata = 32'(use_bias);
      default:          prdata = '0;
    endcase
  end

  // front end: classify words and queue them
  dlga_front #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .IDX_W       (IDX_W),
    .COL_W       (COL_W),
    .OCW         (OCW),
    .RB          (RB),
    .CB          (CB)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .index         (index),
    .column        (column),
    .value         (value),
    .last_in_batch (last_in_batch),
    .output_count  (output_count),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .cmd_row       (cmd_row),
    .cmd_col       (cmd_col)
  );

  // back end: stores, update pipeline and result register
  dlga_back #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .ACC_WIDTH   (ACC_WIDTH),
    .RB          (RB),
    .CB          (CB),
    .CNT_W       (CNT_W),
    .ADDR_W      (ADDR_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .cmd_row     (cmd_row),
    .cmd_col     (cmd_col),
    .input_count (input_count),
    .use_bias    (use_bias),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data),
    .saturated   (saturated),
    .batch_done  (batch_done)
  );

endmodule

[tb/sv/dense_layer_gradient_accumulator_top_test.sv]
// self-checking testbench for the dense layer gradient accumulator
`timescale 1ns / 100ps

module dense_layer_gradient_accumulator_top_test
  import dlga_pkg::*;
();

  localparam int N_IN = 64;
  localparam int N_OUT = 64;
  localparam longint ACC_MAX = 64'sh7F_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  // quiet time before a register write and after the last result: one full row walk and then some
  localparam int IDLE_PAUSE = 80;
  localparam int DRAIN_CYCLES = 100;
  // the longest quiet stretch of a correct run stays well under this limit
  // (row walk + receiver stall + sender gap + pause)
  localparam int WATCHDOG_LIMIT = 2000;
  // enough max-magnitude products to clip a 40-bit accumulator in both directions
  localparam int SAT_RUN = 520;
  localparam logic [5:0] SAT_ROW = 6'd9;

  // expected contents of one result word
  typedef struct {
    logic signed [39:0] data;
    bit                 sat;
    bit                 done;
  } grad_result_t;

  // mirror of the gradient stores plus the queue of result words still owed
  class grad_scoreboard;
    logic signed [15:0] act_buf [N_IN];
    longint             w_acc [N_OUT*N_IN];
    longint             b_acc [N_OUT];
    bit                 sat_seen;
    int unsigned        in_cnt;
    int unsigned        out_cnt;
    bit                 bias_en;
    grad_result_t       owed_q [$];
    int unsigned        fail_count;

    function new();
      foreach (act_buf[i]) act_buf[i] = '0;
      foreach (w_acc[i]) w_acc[i] = 0;
      foreach (b_acc[i]) b_acc[i] = 0;
      sat_seen = 0;
      in_cnt = 64;
      out_cnt = 64;
      bias_en = 1;
      fail_count = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void set_reg(logic [1:0] reg_idx, logic [31:0] data);
      case (reg_idx)
        REG_INPUT_COUNT:  in_cnt = data[6:0];
        REG_OUTPUT_COUNT: out_cnt = data[6:0];
        REG_USE_BIAS:     bias_en = data[0];
        default: ;
      endcase
    endfunction

    // clipped add, sets the sticky flag when it clips
    function longint sat_sum(longint acc, longint add);
      longint s;
      s = acc + add;
      if (s > ACC_MAX) begin
        sat_seen = 1;
        return ACC_MAX;
      end
      if (s < ACC_MIN) begin
        sat_seen = 1;
        return ACC_MIN;
      end
      return s;
    endfunction

    function void note_word(logic [1:0] k, logic [5:0] idx, logic [6:0] col,
                            logic signed [15:0] val, logic last);
      grad_result_t r;
      int unsigned n;
      int row;
      r.data = '0;
      r.done = 0;
      row = int'(idx) * N_IN;
      case (k)
        KIND_LOAD: act_buf[idx] = val;
        KIND_ERROR: begin
          r.done = last;
          if (idx < out_cnt) begin
            n = (in_cnt > N_IN) ? N_IN : in_cnt;
            for (int i = 0; i < n; i++)
              w_acc[row+i] = sat_sum(w_acc[row+i], longint'(val) * longint'(act_buf[i]));
            if (bias_en)
              b_acc[idx] = sat_sum(b_acc[idx], longint'(val) * 4096);
          end
        end
        KIND_READ: begin
          if (col < N_IN)
            r.data = w_acc[row+int'(col)];
          else if (col == N_IN)
            r.data = b_acc[idx];
        end
        KIND_CLEAR: begin
          foreach (w_acc[i]) w_acc[i] = 0;
          foreach (b_acc[i]) b_acc[i] = 0;
          sat_seen = 0;
        end
        default: ;
      endcase
      r.sat = sat_seen;
      owed_q.push_back(r);
    endfunction

    function void check_word(logic signed [39:0] data, logic sat, logic done);
      grad_result_t e;
      if (owed_q.size() == 0) begin
        $error("result word with nothing expected: read_data %0d", data);
        fail_count++;
        return;
      end
      e = owed_q.pop_front();
      if (data !== e.data) begin
        $error("read_data: expected %0d, got %0d", e.data, data);
        fail_count++;
      end
      if (sat !== e.sat) begin
        $error("saturated: expected %0d, got %0d", e.sat, sat);
        fail_count++;
      end
      if (done !== e.done) begin
        $error("batch_done: expected %0d, got %0d", e.done, done);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         kind;
  logic [5:0]         index;
  logic [6:0]         column;
  logic signed [15:0] value;
  logic               last_in_batch;
  logic               out_valid;
  logic               out_ready;
  logic signed [39:0] read_data;
  logic               saturated;
  logic               batch_done;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  grad_scoreboard sb = new();

  // sender state: remaining back-to-back words, and the row most recently hit by an error
  int         send_burst = 0;
  logic [5:0] hot_row = '0;

  dense_layer_gradient_accumulator_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .index         (index),
    .column        (column),
    .value         (value),
    .last_in_batch (last_in_batch),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_data     (read_data),
    .saturated     (saturated),
    .batch_done    (batch_done),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // monitor: values read at the edge are the pre-edge ones, so no ordering race
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_word(read_data, saturated, batch_done);
      if (in_valid && in_ready)
        sb.note_word(kind, index, column, value, last_in_batch);
    end
  end

  // receiver: mostly short stalls, some long ones, and long stretches with no stall
  initial begin
    int r;
    int len;
    bit rdy;
    out_ready <= 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        rdy = 1'b1;
        len = $urandom_range(1, 8);
      end else if (r < 85) begin
        rdy = 1'b0;
        len = $urandom_range(1, 3);
      end else if (r < 95) begin
        rdy = 1'b1;
        len = $urandom_range(50, 150);
      end else begin
        rdy = 1'b0;
        len = $urandom_range(10, 40);
      end
      @(posedge clk);
      out_ready <= rdy;
      repeat (len - 1) @(posedge clk);
    end
  end

  // watchdog: ends the run after too many cycles with no word and no register write
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pwrite && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // one input word: random gap first, then hold valid and payload until accepted
  task automatic send_word(input logic [1:0] k, input logic [5:0] idx, input logic [6:0] col,
                           input logic signed [15:0] val, input logic last);
    int gap;
    int r;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_burst = $urandom_range(20, 80);
        gap = 0;
      end else if (r < 55)
        gap = 0;
      else if (r < 92)
        gap = $urandom_range(1, 3);
      else
        gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    index         <= idx;
    column        <= col;
    value         <= val;
    last_in_batch <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // apb write: setup cycle, access cycle, then a final wait with the bus released
  task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(reg_idx, data);
    @(posedge clk);
  endtask

  // registers change only once every owed result is back and the back end has settled
  task automatic set_config(input int unsigned ic, input int unsigned oc, input bit ub);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
    write_reg(REG_INPUT_COUNT, ic);
    write_reg(REG_OUTPUT_COUNT, oc);
    write_reg(REG_USE_BIAS, 32'(ub));
  endtask

  // random traffic: errors mostly on live rows, reads mostly in range and often on the hot row
  task automatic run_random(input int count);
    int pick;
    int span;
    int r;
    logic [1:0] k;
    logic [5:0] idx;
    logic [6:0] col;
    logic signed [15:0] val;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      idx = 6'($urandom);
      col = 7'($urandom);
      r = $urandom_range(0, 9);
      case (r)
        0: val = 16'sh8000;
        1: val = 16'sh7fff;
        2: val = 16'sh0000;
        3: val = 16'shffff;
        default: val = 16'($urandom);
      endcase
      if (pick < 20)
        k = KIND_LOAD;
      else if (pick < 55) begin
        k = KIND_ERROR;
        span = (sb.out_cnt < N_OUT) ? sb.out_cnt : N_OUT;
        if (span > 0 && $urandom_range(0, 4) != 0)
          idx = 6'($urandom_range(0, span - 1));
        hot_row = idx;
      end else if (pick < 96) begin
        k = KIND_READ;
        if ($urandom_range(0, 1) == 1)
          idx = hot_row;
        r = $urandom_range(0, 9);
        if (r < 8)
          col = 7'($urandom_range(0, N_IN - 1));
        else if (r == 8)
          col = 7'(N_IN);
      end else
        k = KIND_CLEAR;
      send_word(k, idx, col, val, 1'($urandom));
    end
  endtask

  initial begin
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    kind          <= KIND_LOAD;
    index         <= '0;
    column        <= '0;
    value         <= '0;
    last_in_batch <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // every activation gets written before any error word can read it
    send_word(KIND_LOAD, 6'd0, 7'd0, 16'sh8000, 1'b0);
    send_word(KIND_LOAD, 6'd1, 7'd0, 16'sh7fff, 1'b0);
    for (int i = 2; i < N_IN; i++)
      send_word(KIND_LOAD, 6'(i), 7'($urandom), 16'($urandom), 1'($urandom));

    // directed: extreme rows, columns and values at the reset settings
    send_word(KIND_ERROR, 6'd0, 7'd0, 16'sh7fff, 1'b0);
    send_word(KIND_ERROR, 6'd63, 7'd127, 16'sh8000, 1'b1);
    send_word(KIND_ERROR, 6'd5, 7'd0, 16'sh0000, 1'b1);
    send_word(KIND_READ, 6'd0, 7'd0, 16'sh0000, 1'b0);
    send_word(KIND_READ, 6'd0, 7'd63, 16'sh0000, 1'b0);
    send_word(KIND_READ, 6'd0, 7'd64, 16'sh0000, 1'b0);
    send_word(KIND_READ, 6'd63, 7'd64, 16'sh0000, 1'b1);
    send_word(KIND_READ, 6'd63, 7'd1, 16'shffff, 1'b0);
    send_word(KIND_READ, 6'd5, 7'd64, 16'sh0000, 1'b0);
    // columns past the bias slot read back zero
    send_word(KIND_READ, 6'd0, 7'd65, 16'sh0000, 1'b0);
    send_word(KIND_READ, 6'd63, 7'd127, 16'sh0000, 1'b0);
    send_word(KIND_LOAD, 6'd63, 7'd0, 16'sh0000, 1'b1);
    send_word(KIND_ERROR, 6'd63, 7'd0, 16'sh0001, 1'b0);
    send_word(KIND_READ, 6'd63, 7'd63, 16'sh0000, 1'b0);
    send_word(KIND_READ, 6'd63, 7'd0, 16'sh0000, 1'b0);
    // clear wipes gradients but keeps activations
    send_word(KIND_CLEAR, 6'd0, 7'd0, 16'sh0000, 1'b0);
    send_word(KIND_READ, 6'd0, 7'd0, 16'sh0000, 1'b0);
    send_word(KIND_READ, 6'd63, 7'd64, 16'sh0000, 1'b0);
    send_word(KIND_ERROR, 6'd0, 7'd0, 16'shffff, 1'b1);
    send_word(KIND_READ, 6'd0, 7'd0, 16'sh0000, 1'b0);
    send_word(KIND_READ, 6'd0, 7'd1, 16'sh0000, 1'b0);
    send_word(KIND_READ, 6'd0, 7'd64, 16'sh0000, 1'b0);

    // smallest sizes, no bias: error words on rows above zero are out of range
    set_config(1, 1, 1'b0);
    run_random(40);
    // oversized counts clamp to the full array
    set_config(127, 127, 1'b1);
    run_random(40);
    // zero inputs: bias only
    set_config(0, 64, 1'b1);
    run_random(30);
    // zero outputs: every error word is dropped
    set_config(37, 0, 1'b0);
    run_random(30);
    set_config(64, 64, 1'b1);
    run_random(40);
    repeat (3) begin
      set_config($urandom_range(1, 64), $urandom_range(1, 64), 1'($urandom));
      run_random(18);
    end

    // drive one row into clipping: column 0 runs to the top, column 1 to the bottom
    set_config(2, 64, 1'b1);
    send_word(KIND_CLEAR, 6'd0, 7'd0, 16'sh0000, 1'b0);
    send_word(KIND_LOAD, 6'd0, 7'd0, 16'sh8000, 1'b0);
    send_word(KIND_LOAD, 6'd1, 7'd0, 16'sh7fff, 1'b0);
    repeat (SAT_RUN) send_word(KIND_ERROR, SAT_ROW, 7'd0, 16'sh8000, 1'($urandom));
    send_word(KIND_READ, SAT_ROW, 7'd0, 16'sh0000, 1'b0);
    send_word(KIND_READ, SAT_ROW, 7'd1, 16'sh0000, 1'b0);
    send_word(KIND_READ, SAT_ROW, 7'd64, 16'sh0000, 1'b0);
    send_word(KIND_CLEAR, 6'd0, 7'd0, 16'sh0000, 1'b0);
    send_word(KIND_READ, SAT_ROW, 7'd0, 16'sh0000, 1'b0);

    // drain, then give a stray extra word time to show up
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
